// ===== hw/rtl/lbbt_pkg.sv =====
// Shared types and constants for the label bounding box table.
`timescale 1ns / 1ps
package lbbt_pkg;
	localparam int NUM_LABELS = 1024;
	localparam int MAX_EXTENT = 1024;
	localparam int LBL_W      = 10;
	localparam int CW         = 10;
	localparam int EW         = 11;
	localparam int LBL_AW     = $clog2(NUM_LABELS);
	localparam int IN_DW      = 3 * CW + LBL_W;
	localparam int OUT_DW     = 80;

	localparam logic FUNC_ACC  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef logic [2:0][CW-1:0] coord3_t;

	typedef struct packed {
		logic    seen;
		coord3_t lo;
		coord3_t hi;
	} box_entry_t;

	localparam int ENTRY_W = $bits(box_entry_t);
endpackage

// ===== hw/rtl/lbbt_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module lbbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/lbbt_merge.sv =====
// Box growth logic that merges one voxel into a table entry.
`timescale 1ns / 1ps
module lbbt_merge import lbbt_pkg::*; (
	input  box_entry_t old_entry,
	input  coord3_t    pos,
	output box_entry_t new_entry
);
	always_comb begin
		new_entry.seen = 1'b1;
		for (int k = 0; k < 3; k++) begin
			if (!old_entry.seen) begin
				new_entry.lo[k] = pos[k];
				new_entry.hi[k] = pos[k];
			end else begin
				new_entry.lo[k] = (pos[k] < old_entry.lo[k]) ? pos[k] : old_entry.lo[k];
				new_entry.hi[k] = (pos[k] > old_entry.hi[k]) ? pos[k] : old_entry.hi[k];
			end
		end
	end
endmodule

// ===== hw/rtl/label_bounding_box_table.sv =====
// Top level of the per-label 3D bounding box table.
// A read transfer passes the stage-1 registers and then the output register before its result is offered.
// Throughput: one voxel per cycle while the output is not held up; a read in stage 1 holds off the input.
// Each voxel is one read-modify-write of the box memory, with write forwarding.
// After reset a clearing pass zeroes all 1024 entries of the memory; no input is taken then.
`timescale 1ns / 1ps
module label_bounding_box_table import lbbt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// pos_x, pos_y, pos_z, label
	input  logic [IN_DW-1:0]  s_axis_tdata,
	// func
	input  logic              s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// label_out, min_x, min_y, min_z, end_x, end_y, end_z, zero fill
	output logic [OUT_DW-1:0] m_axis_tdata,
	// seen
	output logic              m_axis_tuser
);
	logic              accept;
	logic [LBL_W-1:0]  in_lbl;
	coord3_t           in_pos;
	logic              in_pos_ok;

	logic              clr_busy_q;
	logic [LBL_AW-1:0] clr_addr_q;

	logic              vld_s1;
	logic              func_s1;
	logic [LBL_W-1:0]  lbl_s1;
	coord3_t           pos_s1;
	logic              lbl_ok_s1;
	logic              pos_ok_s1;
	logic [LBL_AW-1:0] addr_s1;

	logic              wr_vld_q;
	logic [LBL_AW-1:0] wr_addr_q;
	box_entry_t        wr_data_q;

	logic [ENTRY_W-1:0] ram_rdata;
	logic               ram_we;
	logic [LBL_AW-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	box_entry_t         cur_entry;
	box_entry_t         new_entry;
	logic               acc_we;
	logic               rd_done;

	logic               out_vld_q;
	logic [LBL_W-1:0]   out_lbl_q;
	logic               out_seen_q;
	coord3_t            out_lo_q;
	logic [2:0][EW-1:0] out_end_q;

	assign in_pos[0] = s_axis_tdata[CW-1:0];
	assign in_pos[1] = s_axis_tdata[2*CW-1:CW];
	assign in_pos[2] = s_axis_tdata[3*CW-1:2*CW];
	assign in_lbl    = s_axis_tdata[IN_DW-1:3*CW];
	assign in_pos_ok = (int'(in_pos[0]) < MAX_EXTENT) && (int'(in_pos[1]) < MAX_EXTENT) &&
		(int'(in_pos[2]) < MAX_EXTENT);

	assign s_axis_tready = !clr_busy_q && !(vld_s1 && func_s1 == FUNC_READ) &&
		(!out_vld_q || m_axis_tready);
	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LBL_AW'(NUM_LABELS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= s_axis_tuser;
			lbl_s1    <= in_lbl;
			pos_s1    <= in_pos;
			lbl_ok_s1 <= int'(in_lbl) < NUM_LABELS;
			pos_ok_s1 <= in_pos_ok;
		end
	end

	assign addr_s1 = lbl_s1[LBL_AW-1:0];

	lbbt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_LABELS)
	) u_box_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(in_lbl[LBL_AW-1:0]),
		.rdata(ram_rdata)
	);

	assign cur_entry = (wr_vld_q && wr_addr_q == addr_s1) ? wr_data_q : box_entry_t'(ram_rdata);

	lbbt_merge u_merge (
		.old_entry(cur_entry),
		.pos      (pos_s1),
		.new_entry(new_entry)
	);

	assign acc_we = vld_s1 && func_s1 == FUNC_ACC && lbl_s1 != '0 && lbl_ok_s1 && pos_ok_s1;
	assign ram_we    = clr_busy_q || acc_we;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : ENTRY_W'(new_entry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else begin
			wr_vld_q <= acc_we;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= new_entry;
		end
	end

	assign rd_done = vld_s1 && func_s1 == FUNC_READ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rd_done) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_done) begin
			out_lbl_q <= lbl_s1;
			if (lbl_ok_s1 && cur_entry.seen) begin
				out_seen_q <= 1'b1;
				for (int k = 0; k < 3; k++) begin
					out_lo_q[k]  <= cur_entry.lo[k];
					out_end_q[k] <= {1'b0, cur_entry.hi[k]} + EW'(1);
				end
			end else begin
				out_seen_q <= 1'b0;
				out_lo_q   <= '0;
				out_end_q  <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_seen_q;
	assign m_axis_tdata  = {7'b0, out_end_q[2], out_end_q[1], out_end_q[0],
		out_lo_q[2], out_lo_q[1], out_lo_q[0], out_lbl_q};

	// The output register is always free when a read leaves the memory stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_done |-> (!out_vld_q || m_axis_tready))
		else $error("read result overwrote a pending result");

	// No voxel reaches the memory while the clearing pass runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!vld_s1 && !acc_we))
		else $error("table update during clearing pass");

	// An unseen entry always holds zero coordinates once clearing is over.
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !cur_entry.seen) |-> (cur_entry.lo == '0 && cur_entry.hi == '0))
		else $error("unseen entry holds stale coordinates");

	// A forwarded write always comes from the update of the previous cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_vld_q |-> $past(acc_we))
		else $error("forwarding register out of step");
endmodule
